@@ sv/kway_merge_of_sorted_runs_top_macros.svh @@
// Assertion macros for the k-way merge engine.
// Included by the top level; no other dependencies.
`ifndef KWAY_MERGE_OF_SORTED_RUNS_TOP_MACROS_SVH
`define KWAY_MERGE_OF_SORTED_RUNS_TOP_MACROS_SVH
`ifndef SYNTH
`define KMRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmrg assertion failed");
`define KMRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmrg assertion failed");
`else
`define KMRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KMRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/kmrg_pkg.sv @@
// Shared constants, command codes and control types of the k-way merge engine.
// No dependencies.
package kmrg_pkg;

  localparam int MAX_RUNS = 16;
  localparam int RUN_W    = $clog2(MAX_RUNS);
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 4;
  localparam int VAL_W    = 64;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REFILL = 2'd2;

  typedef struct packed {
    logic             wr_head;
    logic             set_act;
    logic             clr_act;
    logic             sel_pending;
    logic             scan_init;
    logic             rd_en;
    logic [RUN_W-1:0] rd_addr;
    logic             emit;
  } kmrg_cmd_t;

  typedef struct packed {
    logic pend_active;
    logic out_busy;
  } kmrg_sts_t;

endpackage

@@ sv/kmrg_ifs.sv @@
// Valid/ready channel interfaces for the merge engine input and result beats.
// Depends on kmrg_pkg.
interface kmrg_in_if;
  import kmrg_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] run_index;
  logic [VAL_W-1:0] value;
  logic             has_value;
  modport source (output valid, cmd, run_index, value, has_value, input ready);
  modport sink (input valid, cmd, run_index, value, has_value, output ready);
endinterface

interface kmrg_out_if;
  import kmrg_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] out_value;
  logic [IDX_W-1:0] source_run;
  logic             done_res;
  modport source (output valid, out_value, source_run, done_res, input ready);
  modport sink (input valid, out_value, source_run, done_res, output ready);
endinterface

@@ sv/kmrg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kmrg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ sv/kmrg_dp.sv @@
// Datapath of the merge engine: head memory, active bits, running minimum,
// pending run and the result register. Depends on kmrg_pkg and kmrg_ram.
module kmrg_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kmrg_pkg::kmrg_cmd_t        cmd,
  input  logic [kmrg_pkg::IDX_W-1:0] in_run_index,
  input  logic [kmrg_pkg::VAL_W-1:0] in_value,
  input  logic                       out_ready,
  output kmrg_pkg::kmrg_sts_t        sts,
  output logic                       out_valid,
  output logic [kmrg_pkg::VAL_W-1:0] out_value,
  output logic [kmrg_pkg::IDX_W-1:0] source_run,
  output logic                       done_res
);
  import kmrg_pkg::*;

  logic [MAX_RUNS-1:0] active_r, active_nxt;
  logic [RUN_W-1:0]    pending_r, pending_nxt;
  logic                cmp_vld_r;
  logic [RUN_W-1:0]    cmp_idx_r;
  logic                found_r, found_nxt;
  logic [RUN_W-1:0]    best_idx_r, best_idx_nxt;
  logic [VAL_W-1:0]    best_val_r, best_val_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_value_r;
  logic [IDX_W-1:0]    source_run_r;
  logic                done_r;
  logic [RUN_W-1:0]    wr_addr;
  logic [VAL_W-1:0]    rd_data;
  logic                take;

  assign wr_addr = cmd.sel_pending ? pending_r : RUN_W'(in_run_index);

  kmrg_ram #(.WIDTH(VAL_W), .DEPTH(MAX_RUNS)) u_heads (
    .clk   (clk),
    .we    (cmd.wr_head),
    .waddr (wr_addr),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    active_nxt = active_r;
    if (cmd.set_act) begin
      active_nxt[wr_addr] = 1'b1;
    end
    if (cmd.clr_act) begin
      active_nxt[wr_addr] = 1'b0;
    end
  end

  // One comparator walks the heads; strict less-than keeps the lowest index on ties.
  assign take = cmp_vld_r && active_r[cmp_idx_r] && (!found_r || rd_data < best_val_r);

  always_comb begin
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    if (cmd.scan_init) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt    = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_val_nxt = rd_data;
    end
  end

  assign pending_nxt = (cmd.emit && found_r) ? best_idx_r : pending_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      pending_r   <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pending_r   <= pending_nxt;
      cmp_vld_r   <= cmd.rd_en;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmd.rd_addr;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    if (cmd.emit) begin
      out_value_r  <= found_r ? best_val_r : '0;
      source_run_r <= found_r ? IDX_W'(best_idx_r) : '0;
      done_r       <= !found_r;
    end
  end

  assign sts.pend_active = active_r[pending_r];
  assign sts.out_busy    = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign source_run = source_run_r;
  assign done_res   = done_r;
endmodule

@@ sv/kmrg_ctrl.sv @@
// Controller of the merge engine: decodes accepted beats, sequences the head
// scan and hands the result to the output register. Depends on kmrg_pkg.
module kmrg_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [kmrg_pkg::CMD_W-1:0] in_cmd,
  input  logic [kmrg_pkg::IDX_W-1:0] in_run_index,
  input  logic                       in_has_value,
  input  kmrg_pkg::kmrg_sts_t        sts,
  output logic                       in_ready,
  output kmrg_pkg::kmrg_cmd_t        cmd
);
  import kmrg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             acc;
  logic             run_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign run_ok   = (32'(in_run_index) < MAX_RUNS);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_cmd)
            CMD_LOAD: begin
              cmd.wr_head = run_ok;
              cmd.set_act = run_ok;
            end
            CMD_START: begin
              cmd.scan_init = 1'b1;
              cnt_nxt       = '0;
              state_nxt     = ST_SCAN;
            end
            CMD_REFILL: begin
              // A refill touches the pending run only while that run is active.
              cmd.sel_pending = 1'b1;
              cmd.wr_head     = sts.pend_active && in_has_value;
              cmd.clr_act     = sts.pend_active && !in_has_value;
              cmd.scan_init   = 1'b1;
              cnt_nxt         = '0;
              state_nxt       = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Compares run in the cycle after each read, so a last step issues no read.
        cmd.rd_en   = (cnt_r < CNT_W'(MAX_RUNS));
        cmd.rd_addr = cnt_r[RUN_W-1:0];
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAX_RUNS)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule

@@ sv/kway_merge_of_sorted_runs_top.sv @@
// K-way merge engine: one head per run; a load beat is taken in the idle state, while a start
// or refill beat scans every head and then emits a result beat, using a single
// comparator walking the head memory through its one read port. A new beat is
// accepted as soon as the previous result is registered, even while that result
// still waits on the output side.
// Depends on kmrg_pkg, kmrg_ifs, kmrg_ctrl, kmrg_dp and the assertion macro header.
module kway_merge_of_sorted_runs_top (
  input  logic       clk,
  input  logic       rst_n,
  kmrg_in_if.sink    in_ch,
  kmrg_out_if.source out_ch
);
  import kmrg_pkg::*;

  `include "kway_merge_of_sorted_runs_top_macros.svh"

  kmrg_cmd_t ctl_cmd;
  kmrg_sts_t dp_sts;

  kmrg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_cmd       (in_ch.cmd),
    .in_run_index (in_ch.run_index),
    .in_has_value (in_ch.has_value),
    .sts          (dp_sts),
    .in_ready     (in_ch.ready),
    .cmd          (ctl_cmd)
  );

  kmrg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (ctl_cmd),
    .in_run_index (in_ch.run_index),
    .in_value     (in_ch.value),
    .out_ready    (out_ch.ready),
    .sts          (dp_sts),
    .out_valid    (out_ch.valid),
    .out_value    (out_ch.out_value),
    .source_run   (out_ch.source_run),
    .done_res     (out_ch.done_res)
  );

  `KMRG_ASSERT_IMP(a_emit_slot_free, clk, rst_n, ctl_cmd.emit, !dp_sts.out_busy)
  `KMRG_ASSERT_NXT(a_emit_shows, clk, rst_n, ctl_cmd.emit, out_ch.valid)
  `KMRG_ASSERT_IMP(a_scan_no_accept, clk, rst_n, ctl_cmd.rd_en, !in_ch.ready)
  `KMRG_ASSERT_IMP(a_done_zero, clk, rst_n, out_ch.valid && out_ch.done_res, out_ch.out_value == '0 && out_ch.source_run == '0)
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the k-way merge engine: directed and random beats
// with a predicting scoreboard. Depends on kmrg_pkg, kmrg_ifs and the engine top.

package tb_merge_pkg;
  import kmrg_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] run;
    logic             done;
  } merge_beat_t;

  class merge_scoreboard;
    logic [VAL_W-1:0] heads [MAX_RUNS];
    bit               active [MAX_RUNS];
    logic [IDX_W-1:0] pending;
    merge_beat_t      expected_q [$];
    int               errors;

    function new();
      foreach (active[i]) begin
        active[i] = 1'b0;
        heads[i]  = '0;
      end
      pending = '0;
      errors  = 0;
    endfunction

    function bit any_active();
      foreach (active[i]) if (active[i]) return 1'b1;
      return 1'b0;
    endfunction

    function void queue_expected(merge_beat_t beat);
      expected_q = {expected_q, beat};
    endfunction

    // Smallest active head wins; a strict compare keeps ties on the lowest run.
    function merge_beat_t pick_smallest();
      merge_beat_t beat;
      bit found;
      found = 1'b0;
      beat  = '0;
      for (int i = 0; i < MAX_RUNS; i++) begin
        if (active[i] && (!found || heads[i] < beat.value)) begin
          found      = 1'b1;
          beat.value = heads[i];
          beat.run   = IDX_W'(i);
        end
      end
      if (found) pending = beat.run;
      else beat.done = 1'b1;
      return beat;
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] val, logic has);
      case (cmd)
        CMD_LOAD: begin
          heads[idx]  = val;
          active[idx] = 1'b1;
        end
        CMD_START: queue_expected(pick_smallest());
        CMD_REFILL: begin
          if (active[pending]) begin
            if (has) heads[pending] = val;
            else active[pending] = 1'b0;
          end
          queue_expected(pick_smallest());
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [VAL_W-1:0] val, logic [IDX_W-1:0] run,
                               logic done);
      merge_beat_t exp_beat;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: value %h run %0d done %b",
                 $time, val, run, done);
        return;
      end
      exp_beat = expected_q.pop_front();
      if (val !== exp_beat.value) begin
        errors++;
        $display("%0t: out_value expected %h actual %h", $time, exp_beat.value, val);
      end
      if (run !== exp_beat.run) begin
        errors++;
        $display("%0t: source_run expected %0d actual %0d", $time, exp_beat.run, run);
      end
      if (done !== exp_beat.done) begin
        errors++;
        $display("%0t: done_res expected %b actual %b", $time, exp_beat.done, done);
      end
    endfunction
  endclass
endpackage

module tb_top;
  import kmrg_pkg::*;
  import tb_merge_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   items_sent = 0;
  int   in_idle_pct = 37;
  int   out_idle_pct = 54;

  merge_scoreboard sb = new();

  kmrg_in_if  in_ch ();
  kmrg_out_if out_ch ();

  kway_merge_of_sorted_runs_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: check the beat taken at this edge, then choose the next ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_value, out_ch.source_run, out_ch.done_res);
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Idling runs in three stretches over the item count.
  task automatic update_phase();
    int phase;
    phase = items_sent * 3 / (RANDOM_ITEMS + 20);
    if (phase == 0) begin
      in_idle_pct  = 37;
      out_idle_pct = 54;
    end else if (phase == 1) begin
      in_idle_pct  = 54;
      out_idle_pct = 37;
    end else begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end
  endtask

  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [VAL_W-1:0] val, logic has);
    update_phase();
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.run_index <= idx;
    in_ch.value     <= val;
    in_ch.has_value <= has;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, idx, val, has);
    items_sent++;
  endtask

  function automatic logic [VAL_W-1:0] random_value(int mode);
    case (mode)
      0:       return {$urandom, $urandom};
      1:       return VAL_W'($urandom_range(0, 7));
      2:       return ~VAL_W'($urandom_range(0, 7));
      default: return VAL_W'($urandom) << $urandom_range(0, 32);
    endcase
  endfunction

  // Next element of the run being refilled: usually at or a little above its old head.
  function automatic logic [VAL_W-1:0] next_element(int mode);
    if (sb.active[sb.pending] && $urandom_range(0, 7) != 0)
      return sb.heads[sb.pending] + VAL_W'($urandom_range(0, 3));
    return random_value(mode);
  endfunction

  task automatic send_noise(int count);
    repeat (count)
      send_beat(CMD_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 15)),
                random_value($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  // Load some runs, start, and send mostly refills until every run is exhausted or 300 steps pass.
  task automatic run_merge();
    int mode;
    int exhaust_pct;
    int steps;
    mode        = $urandom_range(0, 3);
    exhaust_pct = $urandom_range(20, 60);
    steps       = 0;
    repeat ($urandom_range(1, 16))
      send_beat(CMD_LOAD, IDX_W'($urandom_range(0, 15)), random_value(mode),
                1'($urandom_range(0, 1)));
    send_beat(CMD_START, IDX_W'($urandom_range(0, 15)), random_value(0),
              1'($urandom_range(0, 1)));
    while (sb.any_active() && steps < 300) begin
      steps++;
      case ($urandom_range(0, 19))
        0: send_beat(CMD_UNUSED, IDX_W'($urandom_range(0, 15)), random_value(0),
                     1'($urandom_range(0, 1)));
        1: send_beat(CMD_START, IDX_W'($urandom_range(0, 15)), random_value(0),
                     1'($urandom_range(0, 1)));
        2: send_beat(CMD_LOAD, IDX_W'($urandom_range(0, 15)), random_value(mode),
                     1'($urandom_range(0, 1)));
        default: send_beat(CMD_REFILL, IDX_W'($urandom_range(0, 15)), next_element(mode),
                           1'($urandom_range(0, 99) >= exhaust_pct));
      endcase
    end
    // Sometimes ask again after the merge has finished.
    if ($urandom_range(0, 2) == 0)
      send_beat(CMD_W'($urandom_range(1, 2)), IDX_W'($urandom_range(0, 15)),
                random_value(0), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_LOAD;
    in_ch.run_index <= '0;
    in_ch.value     <= '0;
    in_ch.has_value <= 1'b0;
    rst_n           <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing loaded: start and refill both give done, and the unused command is dropped.
    send_beat(CMD_START, 4'd0, '0, 1'b0);
    send_beat(CMD_REFILL, 4'd0, '1, 1'b1);
    send_beat(CMD_UNUSED, 4'd5, '1, 1'b1);
    send_beat(CMD_LOAD, 4'd0, '1, 1'b0);
    send_beat(CMD_LOAD, 4'd15, '0, 1'b1);
    send_beat(CMD_LOAD, 4'd7, '0, 1'b0);
    send_beat(CMD_LOAD, 4'd3, {32{2'b01}}, 1'b0);
    // Runs 7 and 15 tie at zero, so run 7 goes first; a second start repeats it.
    send_beat(CMD_START, 4'd15, '1, 1'b1);
    send_beat(CMD_START, 4'd0, '0, 1'b0);
    send_beat(CMD_REFILL, 4'd0, '1, 1'b1);
    send_beat(CMD_REFILL, 4'd0, '0, 1'b0);
    send_beat(CMD_REFILL, 4'd0, '0, 1'b0);
    // A load in the middle of a merge joins the running selection.
    send_beat(CMD_LOAD, 4'd9, {32{2'b10}}, 1'b1);
    send_beat(CMD_REFILL, 4'd15, '0, 1'b1);
    send_beat(CMD_UNUSED, 4'd15, '1, 1'b1);
    send_beat(CMD_REFILL, 4'd0, '1, 1'b0);
    send_beat(CMD_REFILL, 4'd0, '1, 1'b0);
    send_beat(CMD_REFILL, 4'd0, '1, 1'b0);
    send_beat(CMD_REFILL, 4'd0, '1, 1'b0);
    send_beat(CMD_START, 4'd0, '0, 1'b0);

    while (items_sent < RANDOM_ITEMS + 20) begin
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(3, 10));
      else run_merge();
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/kmrg_pkg.sv
sv/kmrg_ifs.sv
sv/kmrg_ram.sv
sv/kmrg_dp.sv
sv/kmrg_ctrl.sv
sv/kway_merge_of_sorted_runs_top.sv
tb/tb_top.sv
